/* hdl/scwf_pkg.sv */
`default_nettype none

package scwf_pkg;

  localparam int DEPTH    = 256;
  localparam int MAX_TAKE = 64;

  localparam int PTR_W    = $clog2(DEPTH);
  localparam int ACTION_W = 2;
  localparam int SAMPLE_W = 3;
  localparam int TAKE_W   = 7;
  localparam int LEAVE_W  = 8;
  localparam int NEED_W   = ((TAKE_W > LEAVE_W) ? TAKE_W : LEAVE_W) + 1;
  localparam int CNT_W    = ((NEED_W > PTR_W) ? NEED_W : PTR_W) + 1;

  localparam int QDEPTH   = 2;
  localparam int QIDX_W   = $clog2(QDEPTH);
  localparam int QFILL_W  = $clog2(QDEPTH + 1);

  localparam logic [ACTION_W-1:0] ACT_CAPTURE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

  typedef enum logic [1:0] {
    CMD_CAPTURE,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [SAMPLE_W-1:0]   bits;
    logic [TAKE_W-1:0]     take;
    logic [LEAVE_W-1:0]    leave;
  } cmd_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

`default_nettype wire

/* hdl/scwf_if.sv */
`default_nettype none

interface scwf_item_if;
  logic                                valid;
  logic                                ready;
  logic [scwf_pkg::ACTION_W-1:0]       action;
  logic [scwf_pkg::SAMPLE_W-1:0]       sample_bits;
  logic [scwf_pkg::TAKE_W-1:0]         take_count;
  logic [scwf_pkg::LEAVE_W-1:0]        leave_count;

  modport source (output valid, action, sample_bits, take_count, leave_count, input ready);
  modport sink   (input valid, action, sample_bits, take_count, leave_count, output ready);
endinterface

interface scwf_result_if;
  logic                                valid;
  logic                                ready;
  logic [scwf_pkg::SAMPLE_W-1:0]       sample;
  logic                                padded;
  logic                                last;

  modport source (output valid, sample, padded, last, input ready);
  modport sink   (input valid, sample, padded, last, output ready);
endinterface

`default_nettype wire

/* hdl/scwf_front.sv */
`default_nettype none

module scwf_front (
  input  wire logic           clk,
  input  wire logic           rst,
  scwf_item_if.sink           item,
  output logic                cmd_valid,
  input  wire logic           cmd_ready,
  output scwf_pkg::cmd_t      cmd
);

  scwf_pkg::cmd_t                   q [scwf_pkg::QDEPTH];
  logic [scwf_pkg::QIDX_W-1:0]      wr_idx;
  logic [scwf_pkg::QIDX_W-1:0]      rd_idx;
  logic [scwf_pkg::QFILL_W-1:0]     fill;

  logic                             accept;
  logic                             keep;
  logic                             push;
  logic                             pop;
  scwf_pkg::cmd_t                   decoded;

  assign item.ready = (fill != scwf_pkg::QFILL_W'(scwf_pkg::QDEPTH));
  assign accept     = item.valid && item.ready;
  assign push       = accept && keep;
  assign cmd_valid  = (fill != '0);
  assign pop        = cmd_valid && cmd_ready;
  assign cmd        = q[rd_idx];

  // Unused action codes are taken and dropped here; they never reach the ring.
  always_comb begin
    keep          = 1'b1;
    decoded.kind  = scwf_pkg::CMD_CAPTURE;
    decoded.bits  = item.sample_bits;
    decoded.leave = item.leave_count;
    decoded.take  = (item.take_count > scwf_pkg::TAKE_W'(scwf_pkg::MAX_TAKE))
                  ? scwf_pkg::TAKE_W'(scwf_pkg::MAX_TAKE) : item.take_count;
    case (item.action)
      scwf_pkg::ACT_CAPTURE: decoded.kind = scwf_pkg::CMD_CAPTURE;
      scwf_pkg::ACT_READ:    decoded.kind = scwf_pkg::CMD_READ;
      scwf_pkg::ACT_CLEAR:   decoded.kind = scwf_pkg::CMD_CLEAR;
      default:               keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_idx] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_idx <= (wr_idx == scwf_pkg::QIDX_W'(scwf_pkg::QDEPTH - 1))
                ? '0 : wr_idx + scwf_pkg::QIDX_W'(1);
      end
      if (pop) begin
        rd_idx <= (rd_idx == scwf_pkg::QIDX_W'(scwf_pkg::QDEPTH - 1))
                ? '0 : rd_idx + scwf_pkg::QIDX_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + scwf_pkg::QFILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - scwf_pkg::QFILL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/scwf_back.sv */
`default_nettype none

module scwf_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_ready,
  input  wire scwf_pkg::cmd_t   cmd,
  scwf_result_if.source         result
);

  scwf_pkg::back_state_t            state;
  scwf_pkg::back_state_t            state_next;

  logic [scwf_pkg::SAMPLE_W-1:0]    mem [scwf_pkg::DEPTH];
  logic [scwf_pkg::SAMPLE_W-1:0]    rd_q;

  logic [scwf_pkg::PTR_W-1:0]       wp;
  logic [scwf_pkg::PTR_W-1:0]       rp;
  logic [scwf_pkg::TAKE_W-1:0]      take_r;
  logic [scwf_pkg::LEAVE_W-1:0]     leave_r;
  logic [scwf_pkg::TAKE_W-1:0]      pad_r;
  logic [scwf_pkg::TAKE_W-1:0]      k;
  logic [scwf_pkg::SAMPLE_W-1:0]    oldest;

  logic                             b_valid;
  logic                             b_pad;
  logic                             b_last;

  logic                             out_valid;
  logic [scwf_pkg::SAMPLE_W-1:0]    out_sample;
  logic                             out_padded;
  logic                             out_last;

  logic                             pop;
  logic                             b_move;
  logic                             b_free;
  logic                             issue;
  logic                             issue_pad;
  logic                             issue_last;
  logic                             wr_en;
  logic                             rd_en;

  logic                             ring_empty;
  logic [scwf_pkg::CNT_W-1:0]       count;
  logic [scwf_pkg::CNT_W-1:0]       need;
  logic [scwf_pkg::CNT_W-1:0]       diff;
  logic [scwf_pkg::CNT_W-1:0]       skip;
  logic [scwf_pkg::PTR_W:0]         rp_sum;
  logic [scwf_pkg::PTR_W-1:0]       rp_setup;
  logic [scwf_pkg::TAKE_W-1:0]      pad_setup;
  logic [scwf_pkg::PTR_W-1:0]       wp_inc;

  assign result.valid  = out_valid;
  assign result.sample = out_sample;
  assign result.padded = out_padded;
  assign result.last   = out_last;

  assign b_move     = b_valid && (!out_valid || result.ready);
  assign b_free     = !b_valid || b_move;
  // A new command waits until the last read data has left rd_q.
  assign cmd_ready  = (state == scwf_pkg::ST_IDLE) && !b_valid;
  assign pop        = cmd_valid && cmd_ready;
  assign issue      = (state == scwf_pkg::ST_EMIT) && b_free;
  assign issue_pad  = (k < pad_r);
  assign issue_last = ((k + scwf_pkg::TAKE_W'(1)) == take_r);
  assign wr_en      = pop && (cmd.kind == scwf_pkg::CMD_CAPTURE);
  assign rd_en      = (pop && (cmd.kind == scwf_pkg::CMD_READ)) || (issue && !issue_pad);
  assign wp_inc     = scwf_pkg::ptr_next(wp);

  // Window setup: occupancy, padding length and how far to skip the oldest excess.
  always_comb begin
    ring_empty = (rp == wp);
    count = (wp >= rp)
          ? (scwf_pkg::CNT_W'(wp) - scwf_pkg::CNT_W'(rp))
          : (scwf_pkg::CNT_W'(wp) + scwf_pkg::CNT_W'(scwf_pkg::DEPTH) - scwf_pkg::CNT_W'(rp));
    need      = scwf_pkg::CNT_W'(take_r) + scwf_pkg::CNT_W'(leave_r);
    diff      = need - count;
    skip      = count - need - scwf_pkg::CNT_W'(1);
    rp_sum    = (scwf_pkg::PTR_W + 1)'(rp) + (scwf_pkg::PTR_W + 1)'(skip);
    rp_setup  = rp;
    pad_setup = '0;
    if (ring_empty) begin
      pad_setup = take_r;
    end else if (need > count) begin
      pad_setup = (diff > scwf_pkg::CNT_W'(take_r)) ? take_r : scwf_pkg::TAKE_W'(diff);
    end else if (count > need + scwf_pkg::CNT_W'(1)) begin
      rp_setup = (rp_sum >= (scwf_pkg::PTR_W + 1)'(scwf_pkg::DEPTH))
               ? scwf_pkg::PTR_W'(rp_sum - (scwf_pkg::PTR_W + 1)'(scwf_pkg::DEPTH))
               : scwf_pkg::PTR_W'(rp_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scwf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      scwf_pkg::ST_IDLE: begin
        if (pop && (cmd.kind == scwf_pkg::CMD_READ)) begin
          state_next = scwf_pkg::ST_SETUP;
        end
      end
      scwf_pkg::ST_SETUP: begin
        state_next = (take_r == '0) ? scwf_pkg::ST_IDLE : scwf_pkg::ST_EMIT;
      end
      scwf_pkg::ST_EMIT: begin
        if (issue && issue_last) begin
          state_next = scwf_pkg::ST_IDLE;
        end
      end
      default: state_next = scwf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= cmd.bits;
    end
    if (rd_en) begin
      rd_q <= mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      rp        <= '0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        wp <= wp_inc;
        // The ring keeps one slot free, so a full ring drops its oldest sample.
        if (wp_inc == rp) begin
          rp <= scwf_pkg::ptr_next(rp);
        end
      end
      if (pop && (cmd.kind == scwf_pkg::CMD_CLEAR)) begin
        rp <= wp;
      end
      if (state == scwf_pkg::ST_SETUP) begin
        rp <= rp_setup;
      end
      if (issue && !issue_pad) begin
        rp <= scwf_pkg::ptr_next(rp);
      end
      if (issue) begin
        b_valid <= 1'b1;
      end else if (b_move) begin
        b_valid <= 1'b0;
      end
      if (b_move) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      take_r  <= cmd.take;
      leave_r <= cmd.leave;
    end
    if (state == scwf_pkg::ST_SETUP) begin
      pad_r  <= pad_setup;
      oldest <= ring_empty ? '0 : rd_q;
      k      <= '0;
    end
    if (issue) begin
      k      <= k + scwf_pkg::TAKE_W'(1);
      b_pad  <= issue_pad;
      b_last <= issue_last;
    end
    if (b_move) begin
      out_sample <= b_pad ? oldest : rd_q;
      out_padded <= b_pad;
      out_last   <= b_last;
    end
  end

`ifndef SYNTHESIS
  a_capture_not_empty: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (rp != wp))
    else $error("ring empty right after a capture");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (pop && (cmd.kind == scwf_pkg::CMD_CLEAR)) |=> (rp == wp))
    else $error("ring not empty right after a clear");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == scwf_pkg::ST_EMIT) |-> (k < take_r))
    else $error("window index past take count");

  a_setup_drained: assert property (@(posedge clk) disable iff (rst)
    (state == scwf_pkg::ST_SETUP) |-> !b_valid)
    else $error("read data still pending during window setup");
`endif

endmodule

`default_nettype wire

/* hdl/signal_capture_window_fifo.sv */
`default_nettype none

// Channel   Role   Payload
// item      sink   action[1:0], sample_bits[2:0], take_count[6:0], leave_count[7:0]
// result    source sample[2:0], padded, last
//
// Items pass through a two-entry command queue; a capture or clear is applied as the
// ring engine takes it, a read passes through a setup state and then streams one
// result per cycle while the sink keeps up, from the single-port ring memory.
// Reset empties the ring by zeroing both pointers; the memory itself is not cleared.
// Results sit in an output register; a stalled sink holds the engine and the queue.

module signal_capture_window_fifo (
  input  wire logic     clk,
  input  wire logic     rst,
  scwf_item_if.sink     item,
  scwf_result_if.source result
);

  logic             cmd_valid;
  logic             cmd_ready;
  scwf_pkg::cmd_t   cmd;

  scwf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  scwf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .result    (result)
  );

endmodule

`default_nettype wire

/* test/tb_signal_capture_window_fifo.sv */
module tb_signal_capture_window_fifo;

  // Action code 3 has no meaning in the block and must be dropped silently.
  localparam logic [scwf_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int FILL_ITEMS    = 270;
  localparam int PHASE_ITEMS   = 38;

  localparam int SEND_IDLE_PCT [4] = '{0, 57, 0, 11};
  localparam int SINK_STALL_PCT[4] = '{0, 0, 57, 11};

  typedef struct packed {
    logic [scwf_pkg::SAMPLE_W-1:0] sample;
    logic                          padded;
    logic                          last;
  } window_beat_t;

  class window_scoreboard;
    logic [scwf_pkg::SAMPLE_W-1:0] ring_mem [scwf_pkg::DEPTH];
    int                            wr_ptr;
    int                            rd_ptr;
    window_beat_t                  window_beats[$];
    int                            mismatches;
    int                            beats_seen;

    function new();
      wr_ptr     = 0;
      rd_ptr     = 0;
      mismatches = 0;
      beats_seen = 0;
    endfunction

    // Updates the ring copy for one accepted item and queues the window it reads out.
    function void note_item(logic [scwf_pkg::ACTION_W-1:0] action,
                            logic [scwf_pkg::SAMPLE_W-1:0] bits,
                            logic [scwf_pkg::TAKE_W-1:0] take,
                            logic [scwf_pkg::LEAVE_W-1:0] leave);
      int                            n_take;
      int                            held;
      int                            need;
      int                            pad;
      logic [scwf_pkg::SAMPLE_W-1:0] oldest;
      case (action)
        scwf_pkg::ACT_CAPTURE: begin
          ring_mem[wr_ptr] = bits;
          wr_ptr = (wr_ptr + 1) % scwf_pkg::DEPTH;
          if (wr_ptr == rd_ptr) rd_ptr = (rd_ptr + 1) % scwf_pkg::DEPTH;
        end
        scwf_pkg::ACT_CLEAR: begin
          rd_ptr = wr_ptr;
        end
        scwf_pkg::ACT_READ: begin
          n_take = (int'(take) > scwf_pkg::MAX_TAKE) ? scwf_pkg::MAX_TAKE : int'(take);
          if (rd_ptr == wr_ptr) begin
            for (int k = 0; k < n_take; k++)
              window_beats.push_back('{sample: '0, padded: 1'b1, last: k == n_take - 1});
          end else begin
            held   = (wr_ptr - rd_ptr + scwf_pkg::DEPTH) % scwf_pkg::DEPTH;
            need   = n_take + int'(leave);
            oldest = ring_mem[rd_ptr];
            pad    = 0;
            if (need > held) begin
              pad = need - held;
              if (pad > n_take) pad = n_take;
            end else if (held > need + 1) begin
              rd_ptr = (rd_ptr + held - need - 1) % scwf_pkg::DEPTH;
            end
            for (int k = 0; k < n_take; k++) begin
              if (k < pad) begin
                window_beats.push_back('{sample: oldest, padded: 1'b1, last: k == n_take - 1});
              end else begin
                window_beats.push_back('{sample: ring_mem[rd_ptr], padded: 1'b0,
                                         last: k == n_take - 1});
                rd_ptr = (rd_ptr + 1) % scwf_pkg::DEPTH;
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report(input string msg);
      mismatches++;
      $display("[%0t] %s", $time, msg);
    endtask

    task check_result(input logic [scwf_pkg::SAMPLE_W-1:0] sample, input logic padded,
                      input logic last);
      window_beat_t want;
      beats_seen++;
      if (window_beats.size() == 0) begin
        report($sformatf("result %0d: unexpected transfer sample=%0d padded=%0b last=%0b",
                         beats_seen, sample, padded, last));
      end else begin
        want = window_beats.pop_front();
        if (sample !== want.sample)
          report($sformatf("result %0d: sample %0d, want %0d", beats_seen, sample,
                           want.sample));
        if (padded !== want.padded)
          report($sformatf("result %0d: padded %0b, want %0b", beats_seen, padded,
                           want.padded));
        if (last !== want.last)
          report($sformatf("result %0d: last %0b, want %0b", beats_seen, last, want.last));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   stall_pct;
  int   cycle_count = 0;

  window_scoreboard sb = new();

  scwf_item_if   item_ch ();
  scwf_result_if res_ch ();

  signal_capture_window_fifo dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.sample, res_ch.padded, res_ch.last);
  end

  // Starts and ends at a falling edge; valid stays high for a following item.
  task automatic send_item(input logic [scwf_pkg::ACTION_W-1:0] action,
                           input logic [scwf_pkg::SAMPLE_W-1:0] bits,
                           input logic [scwf_pkg::TAKE_W-1:0] take,
                           input logic [scwf_pkg::LEAVE_W-1:0] leave);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.action      <= action;
    item_ch.sample_bits <= bits;
    item_ch.take_count  <= take;
    item_ch.leave_count <= leave;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_item(action, bits, take, leave);
    @(negedge clk);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (sb.window_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [scwf_pkg::SAMPLE_W-1:0] random_bits();
    return scwf_pkg::SAMPLE_W'($urandom_range(0, 7));
  endfunction

  function automatic logic [scwf_pkg::TAKE_W-1:0] random_any_take();
    return scwf_pkg::TAKE_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [scwf_pkg::LEAVE_W-1:0] random_any_leave();
    return scwf_pkg::LEAVE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [scwf_pkg::TAKE_W-1:0] random_take();
    int r;
    r = $urandom_range(99);
    if (r < 75) return scwf_pkg::TAKE_W'($urandom_range(0, 8));
    if (r < 90) return scwf_pkg::TAKE_W'($urandom_range(9, scwf_pkg::MAX_TAKE));
    return scwf_pkg::TAKE_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [scwf_pkg::LEAVE_W-1:0] random_leave();
    int r;
    r = $urandom_range(99);
    if (r < 50) return scwf_pkg::LEAVE_W'($urandom_range(0, 6));
    if (r < 80) return scwf_pkg::LEAVE_W'($urandom_range(0, 40));
    return scwf_pkg::LEAVE_W'($urandom_range(0, 255));
  endfunction

  // Unused actions are sent as noise but do not count toward the phase.
  task automatic random_item(inout int counted);
    int r;
    r = $urandom_range(99);
    if (r < 58) begin
      send_item(scwf_pkg::ACT_CAPTURE, random_bits(), random_any_take(), random_any_leave());
      counted++;
    end else if (r < 90) begin
      send_item(scwf_pkg::ACT_READ, random_bits(), random_take(), random_leave());
      counted++;
    end else if (r < 96) begin
      send_item(scwf_pkg::ACT_CLEAR, random_bits(), random_any_take(), random_any_leave());
      counted++;
    end else begin
      send_item(ACT_UNUSED, random_bits(), random_any_take(), random_any_leave());
    end
  endtask

  initial begin
    int counted;
    rst                 = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.action      = scwf_pkg::ACT_CAPTURE;
    item_ch.sample_bits = '0;
    item_ch.take_count  = '0;
    item_ch.leave_count = '0;
    send_idle_pct       = 0;
    stall_pct           = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty ring gives zero fill; a zero take gives nothing.
    send_item(scwf_pkg::ACT_READ, 3'd0, 7'd3, 8'd0);
    send_item(scwf_pkg::ACT_READ, 3'd0, 7'd0, 8'd0);
    send_item(ACT_UNUSED, 3'd7, 7'd127, 8'd255);
    send_item(scwf_pkg::ACT_CAPTURE, 3'd0, 7'd0, 8'd0);
    send_item(scwf_pkg::ACT_CAPTURE, 3'd7, 7'd127, 8'd255);
    send_item(scwf_pkg::ACT_CAPTURE, 3'd1, 7'd0, 8'd0);
    send_item(scwf_pkg::ACT_CAPTURE, 3'd2, 7'd0, 8'd0);
    send_item(scwf_pkg::ACT_CAPTURE, 3'd4, 7'd0, 8'd0);
    send_item(scwf_pkg::ACT_CAPTURE, 3'd6, 7'd0, 8'd0);
    // Six held, window of two with nothing left behind: the excess is skipped.
    send_item(scwf_pkg::ACT_READ, 3'd0, 7'd2, 8'd0);
    send_item(scwf_pkg::ACT_CAPTURE, 3'd3, 7'd0, 8'd0);
    send_item(scwf_pkg::ACT_CAPTURE, 3'd5, 7'd0, 8'd0);
    // Padding as long as the take covers the whole window.
    send_item(scwf_pkg::ACT_READ, 3'd0, 7'd5, 8'd3);
    send_item(scwf_pkg::ACT_READ, 3'd0, 7'd2, 8'd0);
    send_item(scwf_pkg::ACT_READ, 3'd7, 7'd127, 8'd255);
    send_item(scwf_pkg::ACT_READ, 3'd0, 7'd64, 8'd0);
    send_item(scwf_pkg::ACT_CLEAR, 3'd0, 7'd0, 8'd0);
    send_item(scwf_pkg::ACT_READ, 3'd0, 7'd1, 8'd255);
    send_item(scwf_pkg::ACT_CAPTURE, 3'd7, 7'd0, 8'd0);
    send_item(scwf_pkg::ACT_READ, 3'd0, 7'd0, 8'd0);
    send_item(scwf_pkg::ACT_CAPTURE, 3'd1, 7'd0, 8'd0);
    send_item(scwf_pkg::ACT_CAPTURE, 3'd2, 7'd0, 8'd0);
    send_item(scwf_pkg::ACT_CAPTURE, 3'd4, 7'd0, 8'd0);
    // A zero take still trims the ring down to one sample.
    send_item(scwf_pkg::ACT_READ, 3'd0, 7'd0, 8'd0);
    send_item(scwf_pkg::ACT_READ, 3'd0, 7'd1, 8'd0);
    drain();

    // Long capture run fills the ring, overwrites the oldest and wraps both pointers.
    send_idle_pct = SEND_IDLE_PCT[1];
    for (int i = 0; i < FILL_ITEMS; i++) begin
      if (i % 30 == 29)
        send_item(scwf_pkg::ACT_READ, random_bits(), scwf_pkg::TAKE_W'($urandom_range(0, 8)),
                  scwf_pkg::LEAVE_W'($urandom_range(200, 255)));
      else
        send_item(scwf_pkg::ACT_CAPTURE, random_bits(), random_any_take(),
                  random_any_leave());
    end
    send_item(scwf_pkg::ACT_READ, 3'd0, 7'd64, 8'd255);
    send_item(scwf_pkg::ACT_READ, 3'd0, 7'd20, 8'd100);
    send_item(scwf_pkg::ACT_READ, 3'd0, 7'd10, 8'd0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = SEND_IDLE_PCT[ph];
      stall_pct     = SINK_STALL_PCT[ph];
      counted       = 0;
      while (counted < PHASE_ITEMS) random_item(counted);
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* signal_capture_window_fifo.f */
hdl/scwf_pkg.sv
hdl/scwf_if.sv
hdl/scwf_front.sv
hdl/scwf_back.sv
hdl/signal_capture_window_fifo.sv
test/tb_signal_capture_window_fifo.sv
